/* rtl/core/rotated_sorted_array_search_top_macros.svh */
// Assertion macros shared by the rotated sorted array search RTL.
// Depends on nothing; included by the top level only.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_TOP_MACROS_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define RSAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define RSAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rsas_pkg.sv */
// Package of the rotated sorted array search block: request and result types,
// function codes, sequencer states. Depends on nothing.
package rsas_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    // Search bounds carry a sign bit and one headroom bit: low reaches 1024,
    // high reaches -1.
    localparam int BND_W = IDX_W + 2;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    typedef struct packed {
        t_func                    func;
        logic [IDX_W-1:0]         load_index;
        logic signed [VAL_W-1:0]  load_value;
        logic signed [VAL_W-1:0]  key;
        logic [IDX_W-1:0]         range_low;
        logic [IDX_W-1:0]         range_high;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } t_rsp;

    // Decision of the compare unit for one halving step.
    typedef struct packed {
        logic match;    // midpoint element equals the key
        logic go_left;  // keep the lower half: high = mid - 1
    } t_step;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MID  = 4'b0010,
        S_LOW  = 4'b0100,
        S_DEC  = 4'b1000
    } t_state;

endpackage

/* rtl/core/rsas_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/rsas_cmp.sv */
// Shared compare unit: decides match and search direction for one step.
// Depends on rsas_pkg.
module rsas_cmp
    import rsas_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic signed [DATA_WIDTH-1:0] i_am,
    input  logic signed [DATA_WIDTH-1:0] i_al,
    input  logic signed [DATA_WIDTH-1:0] i_key,
    output t_step                        o_step
);

    always_comb begin
        o_step.match = (i_am == i_key);
        if (i_am >= i_al) begin
            // Left half is sorted: go left only if the key lies inside it.
            o_step.go_left = (i_key < i_am) && (i_key >= i_al);
        end else begin
            // Right half is sorted: go right only if the key lies inside it.
            o_step.go_left = !((i_key > i_am) && (i_key < i_al));
        end
    end

endmodule

/* rtl/core/rotated_sorted_array_search_top.sv */
// Top level of the rotated sorted array search block.
// Depends on rsas_pkg, rsas_ram, rsas_cmp and the assertion macro header.
//
//   Channel   Handshake          Payload   Direction
//   request   start / busy       i_req     in
//   result    o_done (strobe)    o_res     out
//
// A load request writes the element store in the cycle it is accepted and
// leaves busy low, so loads can follow back to back. A search request goes
// through read midpoint, read lower-bound element and decide for each
// halving step, as the element store has a single read port, plus a last
// visit to the midpoint state that finds the bounds crossed when the key is
// absent. The result strobe rises in the same cycle that busy falls, and a
// new request may be accepted in the strobe cycle. Reset is synchronous and
// active low; it clears the sequencer and the result strobe, not the store.
// The result is shown for one cycle and cannot be stalled.
`include "rotated_sorted_array_search_top_macros.svh"

module rotated_sorted_array_search_top
    import rsas_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_res
);

    localparam int AW = $clog2(DEPTH);

    // Sign-extend a 32-bit field, then reduce it to the element width.
    function automatic logic [DATA_WIDTH-1:0] to_elem(input logic [VAL_W-1:0] v);
        logic [63:0] v64;
        v64 = {{(64 - VAL_W){v[VAL_W-1]}}, v};
        return v64[DATA_WIDTH-1:0];
    endfunction

    // Index fields are narrower than the largest store; positions past the
    // store are ignored on write and read as zero.
    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        logic [31:0] ext;
        ext = {{(32 - IDX_W){1'b0}}, idx};
        return ext < 32'(DEPTH);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] ext;
        ext = {{(32 - IDX_W){1'b0}}, idx};
        return ext[AW-1:0];
    endfunction

    t_state                        r_state, n_state;
    logic signed [BND_W-1:0]       r_low, n_low;
    logic signed [BND_W-1:0]       r_high, n_high;
    logic signed [BND_W-1:0]       r_mid, n_mid;
    logic signed [DATA_WIDTH-1:0]  r_key, n_key;
    logic signed [DATA_WIDTH-1:0]  r_am, n_am;
    logic                          r_rd_zero, n_rd_zero;
    logic                          r_done, n_done;
    t_rsp                          r_res, n_res;

    logic                          accept;
    logic                          ram_we;
    logic [IDX_W-1:0]              rd_idx;
    logic [DATA_WIDTH-1:0]         ram_rdata;
    logic signed [DATA_WIDTH-1:0]  rd_val;
    logic signed [BND_W-1:0]       mid_calc;
    logic signed [BND_W-1:0]       span;
    logic signed [DATA_WIDTH-1:0]  cmp_am;
    t_step                         step;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign ram_we = accept && (i_req.func == FUNC_LOAD) && in_range(i_req.load_index);

    // Midpoint of the current bounds; the span is never negative here.
    assign span     = r_high - r_low;
    assign mid_calc = r_low + (span >>> 1);

    // Read data of an out-of-store position is replaced by zero.
    assign rd_val = r_rd_zero ? '0 : $signed(ram_rdata);

    // In the low-read state the midpoint element arrives; in the decide
    // state it comes from its holding register.
    assign cmp_am = (r_state == S_LOW) ? rd_val : r_am;

    rsas_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (to_addr(i_req.load_index)),
        .i_wdata (to_elem(i_req.load_value)),
        .i_raddr (to_addr(rd_idx)),
        .o_rdata (ram_rdata)
    );

    rsas_cmp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmp (
        .i_am   (cmp_am),
        .i_al   (rd_val),
        .i_key  (r_key),
        .o_step (step)
    );

    always_comb begin
        n_state   = r_state;
        n_low     = r_low;
        n_high    = r_high;
        n_mid     = r_mid;
        n_key     = r_key;
        n_am      = r_am;
        n_done    = 1'b0;
        n_res     = r_res;
        rd_idx    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.func == FUNC_SEARCH)) begin
                    n_low   = BND_W'({2'b00, i_req.range_low});
                    n_high  = BND_W'({2'b00, i_req.range_high});
                    n_key   = to_elem(i_req.key);
                    n_state = S_MID;
                end
            end
            S_MID: begin
                // Crossed bounds end the search without a match.
                if (r_low > r_high) begin
                    n_done         = 1'b1;
                    n_res.found    = 1'b0;
                    n_res.position = '0;
                    n_state        = S_IDLE;
                end else begin
                    rd_idx  = mid_calc[IDX_W-1:0];
                    n_mid   = mid_calc;
                    n_state = S_LOW;
                end
            end
            S_LOW: begin
                // Midpoint element is on the read port; a match ends early.
                n_am = rd_val;
                if (step.match) begin
                    n_done         = 1'b1;
                    n_res.found    = 1'b1;
                    n_res.position = r_mid[IDX_W-1:0];
                    n_state        = S_IDLE;
                end else begin
                    rd_idx  = r_low[IDX_W-1:0];
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // Lower-bound element is on the read port: narrow the range.
                if (step.go_left) begin
                    n_high = r_mid - BND_W'(1);
                end else begin
                    n_low  = r_mid + BND_W'(1);
                end
                n_state = S_MID;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rd_zero = !in_range(rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low     <= n_low;
        r_high    <= n_high;
        r_mid     <= n_mid;
        r_key     <= n_key;
        r_am      <= n_am;
        r_rd_zero <= n_rd_zero;
        r_res     <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // A result is only delivered once the sequencer is back at rest.
    `RSAS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")
    // A not-found result always carries position zero.
    `RSAS_ASSERT_NOW(a_miss_pos, i_clk, i_rst_n, o_done && !o_res.found,
        o_res.position == '0, "miss with nonzero position")
    // An accepted search occupies the block in the following cycle.
    `RSAS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, accept && (i_req.func == FUNC_SEARCH),
        busy && !o_done, "search not started")
    // Every decide step goes on to a new midpoint.
    `RSAS_ASSERT_NEXT(a_dec_mid, i_clk, i_rst_n, r_state == S_DEC,
        r_state == S_MID, "decide step did not return to midpoint")

endmodule

/* tb/sv/rotated_sorted_array_search_top_tb.sv */
// Self-checking testbench for the rotated sorted array search block.
// Depends on rsas_pkg and rotated_sorted_array_search_top; it keeps its own copy of the
// element store and predicts every search result in a small scoreboard class.
`timescale 1ns / 100ps

module rotated_sorted_array_search_top_tb
    import rsas_pkg::*;
();

    localparam int DEPTH        = 1024;
    localparam int N_ITEMS      = 400;
    // From this request count on, the sender no longer idles.
    localparam int CALM_AFTER   = 320;
    // Extra wait at the end, after every open search has delivered its result.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int VAL_MIN      = 32'sh8000_0000;
    localparam int VAL_MAX      = 32'sh7FFF_FFFF;

    // The scoreboard mirrors the element store. A load request updates the copy,
    // and a search request is answered at once from the copy and queued until the
    // block delivers its result.
    class search_scoreboard;
        logic signed [VAL_W-1:0] element_copy [DEPTH];
        bit                      written_map [DEPTH];
        t_rsp                    pending_results [$];
        int                      errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Binary search over a rotated ascending array, with the same decisions
        // as the hardware: match at the midpoint, else pick the sorted half by
        // comparing the midpoint element with the lower-bound element.
        function t_rsp predict_search(t_req req);
            int                      lo;
            int                      hi;
            int                      mid;
            logic signed [VAL_W-1:0] am;
            logic signed [VAL_W-1:0] al;
            logic signed [VAL_W-1:0] k;
            t_rsp                    res;
            res = '0;
            lo  = int'(req.range_low);
            hi  = int'(req.range_high);
            k   = req.key;
            while (lo <= hi && !res.found) begin
                mid = lo + (hi - lo) / 2;
                am  = element_copy[mid];
                al  = element_copy[lo];
                if (am == k) begin
                    res.found    = 1'b1;
                    res.position = IDX_W'(mid);
                end else if (am >= al) begin
                    if (k < am && k >= al) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end else begin
                    if (k > am && k < al) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            return res;
        endfunction

        // True when every entry of [lo, hi] has been loaded (or the range is empty).
        function bit range_written(int lo, int hi);
            for (int i = lo; i <= hi; i++) begin
                if (!written_map[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(t_req req);
            if (req.func == FUNC_LOAD) begin
                element_copy[req.load_index] = req.load_value;
                written_map[req.load_index]  = 1'b1;
            end else begin
                pending_results.push_back(predict_search(req));
            end
        endfunction

        task check_result(t_rsp got);
            t_rsp want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result found=%0b position=%0d with no search open",
                                          got.found, got.position));
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found) begin
                    report_mismatch($sformatf("found=%0b, predicted %0b",
                                              got.found, want.found));
                end
                if (got.position !== want.position) begin
                    report_mismatch($sformatf("position=%0d, predicted %0d",
                                              got.position, want.position));
                end
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_done;
    t_rsp o_res;

    search_scoreboard sb;
    int   item_count  = 0;
    int   cycle_count = 0;
    // Chance in percent that the sender pauses before a request.
    int   idle_pct    = 0;
    bit   calm        = 1'b0;
    // One rotated ascending segment, in store order.
    int   seg_vals [$];

    rotated_sorted_array_search_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VAL_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // 2 ns clock: one delay for the high phase, one for the low phase.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or never delivers a result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Results cannot be stalled, so every strobe seen at a rising edge is taken
    // and compared with the oldest open search. Values sampled here are the ones
    // from before the edge, since the block updates through nonblocking writes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_result(o_res);
        end
    end

    // A request with every field random; the unused fields of a load or a
    // search are left random on purpose, so that every bit toggles.
    function automatic t_req random_req();
        t_req r;
        r.func       = ($urandom_range(0, 1) == 0) ? FUNC_LOAD : FUNC_SEARCH;
        r.load_index = IDX_W'($urandom_range(0, DEPTH - 1));
        r.load_value = $urandom;
        r.key        = $urandom;
        r.range_low  = IDX_W'($urandom_range(0, DEPTH - 1));
        r.range_high = IDX_W'($urandom_range(0, DEPTH - 1));
        return r;
    endfunction

    // Presents one request and holds it until the block accepts it, that is
    // until a rising edge sees start high and busy low. Before that it may idle
    // for a random burst, with start low and junk on the payload.
    task automatic send_request(t_req r);
        int gap;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            i_req <= random_req();
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(r);
        item_count++;
        if (item_count >= CALM_AFTER) calm = 1'b1;
    endtask

    task automatic load_element(int idx, int val);
        t_req r;
        r            = random_req();
        r.func       = FUNC_LOAD;
        r.load_index = IDX_W'(idx);
        r.load_value = val;
        send_request(r);
    endtask

    task automatic search_key(int key, int lo, int hi);
        t_req r;
        r            = random_req();
        r.func       = FUNC_SEARCH;
        r.key        = key;
        r.range_low  = IDX_W'(lo);
        r.range_high = IDX_W'(hi);
        send_request(r);
    endtask

    // Builds n distinct ascending values and rotates them by a random amount.
    // Values are either clustered near zero, consecutive, or spread over the
    // whole signed range, sometimes with both extremes included.
    task automatic build_segment(int n);
        int     mode;
        int     rot;
        longint span;
        longint v;
        int     asc [$];
        asc      = {};
        seg_vals = {};
        mode     = $urandom_range(0, 2);
        span     = 64'd4294967296 / (n + 1);
        if (mode == 0) begin
            v = longint'($urandom_range(0, 40)) - 60;
        end else if (mode == 1) begin
            v = longint'(int'($urandom));
            if (v > longint'(VAL_MAX) - n) v = longint'(VAL_MAX) - n;
        end else begin
            v = longint'(VAL_MIN) + longint'($urandom_range(0, 32'(span - 1)));
        end
        for (int i = 0; i < n; i++) begin
            asc.push_back(int'(v));
            if (mode == 0) begin
                v += longint'($urandom_range(1, 3));
            end else if (mode == 1) begin
                v += 1;
            end else begin
                v += longint'($urandom_range(1, 32'(span)));
            end
        end
        if (mode == 2 && $urandom_range(0, 3) == 0) begin
            asc[0]     = VAL_MIN;
            asc[n - 1] = VAL_MAX;
        end
        rot = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
            seg_vals.push_back(asc[(i + rot) % n]);
        end
    endtask

    // Well-formed use: load one rotated segment, then search it. Keys are mostly
    // elements of the segment, else their neighbors, the extremes or anything.
    task automatic run_segment_sequence(int n, int searches);
        int base;
        int top;
        int pick;
        int key;
        int lo;
        int hi;
        build_segment(n);
        case ($urandom_range(0, 5))
            0:       base = 0;
            1:       base = DEPTH - n;
            default: base = $urandom_range(0, DEPTH - n);
        endcase
        top = base + n - 1;
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < n; i++) load_element(base + i, seg_vals[i]);
        end else begin
            for (int i = n - 1; i >= 0; i--) load_element(base + i, seg_vals[i]);
        end
        repeat (searches) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                key = seg_vals[$urandom_range(0, n - 1)];
            end else if (pick < 7) begin
                key = seg_vals[$urandom_range(0, n - 1)] + (($urandom_range(0, 1) == 0) ? 1 : -1);
            end else if (pick < 8) begin
                key = ($urandom_range(0, 1) == 0) ? VAL_MIN : VAL_MAX;
            end else begin
                key = $urandom;
            end
            // Mostly the whole segment; sometimes a part of it, which may be crossed.
            if ($urandom_range(0, 4) != 0) begin
                lo = base;
                hi = top;
            end else begin
                lo = $urandom_range(base, top);
                hi = $urandom_range(base, top);
            end
            search_key(key, lo, hi);
        end
    endtask

    // Stray loads that break the ordering of whatever segment they land in.
    task automatic run_noise_loads();
        repeat ($urandom_range(1, 4)) begin
            load_element($urandom_range(0, DEPTH - 1), $urandom);
        end
    endtask

    // A search over a random window. Only windows that are fully loaded may be
    // searched, since an unloaded entry has no defined value; any other window
    // is turned into a crossed range, which reads nothing.
    task automatic run_noise_search();
        int lo;
        int hi;
        int key;
        lo = $urandom_range(0, DEPTH - 1);
        hi = lo + $urandom_range(0, 31);
        if (hi > DEPTH - 1) hi = DEPTH - 1;
        if ($urandom_range(0, 1) == 0 && sb.written_map[lo]) begin
            key = sb.element_copy[lo];
        end else begin
            key = $urandom;
        end
        if (!sb.range_written(lo, hi)) begin
            lo = $urandom_range(1, DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
        end
        search_key(key, lo, hi);
    endtask

    initial begin : main_flow
        int choice;
        sb = new();

        // Synchronous reset, held at the start and never asserted again.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A rotated segment at the bottom of the store holds both
        // value extremes, and an unrotated one at the top lets the lower bound
        // run past the last index when the key is above every element.
        load_element(0, 10);
        load_element(1, VAL_MAX);
        load_element(2, VAL_MIN);
        load_element(3, -5);
        load_element(1020, -7);
        load_element(1021, 0);
        load_element(1022, 3);
        load_element(1023, 100);
        search_key(10, 0, 3);
        search_key(VAL_MAX, 0, 3);
        search_key(VAL_MIN, 0, 3);
        search_key(-5, 0, 3);
        search_key(11, 0, 3);
        search_key(-6, 0, 3);
        search_key(-7, 1020, 1023);
        search_key(100, 1020, 1023);
        search_key(1000, 1020, 1023);
        search_key(VAL_MIN, 1020, 1023);
        search_key(100, 1023, 1023);
        search_key(10, 0, 0);
        // Bounds that are crossed from the outset give not found without a read.
        search_key(VAL_MAX, 1023, 0);
        search_key(0, 5, 4);
        // Overwriting an element must be seen by the next search.
        load_element(3, 0);
        search_key(0, 0, 3);

        // Random part: mostly segments with searches, some noise, and now and
        // then one larger segment. Idling changes from phase to phase.
        while (item_count < N_ITEMS) begin
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 60);
            choice   = $urandom_range(0, 19);
            if (choice == 0) begin
                run_segment_sequence($urandom_range(48, 96), 8);
            end else if (choice < 15) begin
                run_segment_sequence($urandom_range(1, 24), $urandom_range(1, 6));
            end else if (choice < 18) begin
                run_noise_loads();
            end else begin
                run_noise_search();
            end
        end

        // Drain: wait for every open search, then watch a while longer for any
        // result that should not come.
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
